@@ src/hse_pkg.sv @@
// ----------------------------------------------------------------------------
// hse_pkg: shared types for the hash set engine
// Request and response payloads, operation codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package hse_pkg;

   // Width of the key field on the request channel
   localparam int unsigned KEY_W = 20;

   // Operation codes; the unused code behaves as a lookup
   typedef enum logic [1:0] {
      KIND_ADD      = 2'd0,
      KIND_REMOVE   = 2'd1,
      KIND_CONTAINS = 2'd2
   } hse_kind_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [KEY_W-1:0] key;
   } hse_req_type;

   typedef struct packed {
      logic present;
      logic status;
   } hse_rsp_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_QUOT,
      ST_PROD,
      ST_MOD,
      ST_READ,
      ST_UPDATE
   } hse_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;     // capture the request transaction
      logic clear;    // write one empty valid row, advance the sweep
      logic update;   // commit the bucket row and load the response
   } hse_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;   // sweep is at the last bucket row
   } hse_stat_type;

endpackage

`default_nettype wire

@@ src/hse_datapath.sv @@
// ----------------------------------------------------------------------------
// hse_datapath: bucket index, row storage and way compare
// Reduces the key modulo the bucket count by reciprocal multiplication,
// reads one bucket row, matches all ways and writes the updated row back.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_datapath #(
   parameter int unsigned BUCKETS  = 1024,
   parameter int unsigned WAYS     = 4,
   parameter int unsigned KEY_BITS = 20
) (
   input  wire                   clock,
   input  wire                   reset,
   input  hse_pkg::hse_cmd_type  cmd,
   output hse_pkg::hse_stat_type stat,
   input  hse_pkg::hse_req_type  req_data,
   output hse_pkg::hse_rsp_type  rsp_data
);

   // Stored key width: the port carries KEY_W bits, masked to KEY_BITS
   localparam int unsigned N   = (KEY_BITS < hse_pkg::KEY_W) ? KEY_BITS : hse_pkg::KEY_W;
   localparam int unsigned BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int unsigned BCW = $clog2(BUCKETS + 1);
   localparam int unsigned RMW = ((N > BW) ? N : BW) + 1;
   localparam int unsigned WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
   // floor(2^N / BUCKETS): quotient estimate is exact or one low
   localparam logic [N-1:0]   RECIP   = N'((64'd1 << N) / BUCKETS);
   localparam logic [BCW-1:0] BKT_CNT = BCW'(BUCKETS);
   localparam logic [RMW-1:0] BKT_RM  = RMW'(BUCKETS);
   localparam logic [BW-1:0]  BKT_LST = BW'(BUCKETS - 1);

   // Request capture
   hse_pkg::hse_kind_type kind_ff;
   logic [N-1:0]          key_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= hse_pkg::hse_kind_type'(req_data.kind);
         key_ff  <= req_data.key[N-1:0];
      end
   end

   // Bucket index pipeline: quotient, product, remainder with correction
   logic [N-1:0]     quot_ff;
   logic [N-1:0]     prod_ff;
   logic [BW-1:0]    bucket_ff;
   logic [2*N-1:0]   quot_full;
   logic [N+BCW-1:0] prod_full;
   logic [RMW-1:0]   rem_raw;
   logic [RMW-1:0]   rem_fix;

   always_comb begin
      quot_full = key_ff * RECIP;
      prod_full = quot_ff * BKT_CNT;
      rem_raw   = RMW'(key_ff) - RMW'(prod_ff);
      rem_fix   = (rem_raw >= BKT_RM) ? (rem_raw - BKT_RM) : rem_raw;
   end

   always_ff @(posedge clock) begin
      quot_ff   <= quot_full[2*N-1:N];
      prod_ff   <= prod_full[N-1:0];
      bucket_ff <= rem_fix[BW-1:0];
   end

   // Clearing sweep over the valid rows after reset
   logic [BW-1:0] clr_cnt_ff;
   logic [BW-1:0] clr_cnt_in;

   assign clr_cnt_in      = cmd.clear ? (clr_cnt_ff + BW'(1)) : clr_cnt_ff;
   assign stat.clear_last = (clr_cnt_ff == BKT_LST);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Row storage: keys undefined until written, valid rows swept at reset
   logic [WAYS-1:0][N-1:0] key_mem   [BUCKETS];
   logic [WAYS-1:0]        valid_mem [BUCKETS];
   logic [WAYS-1:0][N-1:0] rd_keys_ff;
   logic [WAYS-1:0]        rd_valid_ff;

   // Way match and row update
   logic [WAYS-1:0][N-1:0] new_keys;
   logic [WAYS-1:0]        upd_valid;
   logic [WAYS-1:0]        wr_valid;
   logic [BW-1:0]          valid_addr;
   logic                   key_we;
   logic                   valid_we;
   logic                   hit;
   logic                   free;
   logic [WW-1:0]          hit_way;
   logic [WW-1:0]          free_way;
   hse_pkg::hse_rsp_type   rsp_in;

   always_comb begin
      hit      = 1'b0;
      free     = 1'b0;
      hit_way  = '0;
      free_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (rd_valid_ff[w]) begin
            if (!hit && (rd_keys_ff[w] == key_ff)) begin
               hit     = 1'b1;
               hit_way = WW'(w);
            end
         end else if (!free) begin
            free     = 1'b1;
            free_way = WW'(w);
         end
      end

      new_keys       = rd_keys_ff;
      upd_valid      = rd_valid_ff;
      key_we         = 1'b0;
      rsp_in.present = hit;
      rsp_in.status  = 1'b0;
      case (kind_ff)
         hse_pkg::KIND_ADD: begin
            if (!hit) begin
               if (free) begin
                  new_keys[free_way]  = key_ff;
                  upd_valid[free_way] = 1'b1;
                  key_we              = cmd.update;
               end else begin
                  rsp_in.status = 1'b1;
               end
            end
         end
         hse_pkg::KIND_REMOVE: begin
            if (hit) begin
               upd_valid[hit_way] = 1'b0;
            end
         end
         default: begin
            // lookup: the row is written back unchanged
         end
      endcase

      valid_we   = cmd.clear | cmd.update;
      valid_addr = cmd.clear ? clr_cnt_ff : bucket_ff;
      wr_valid   = cmd.clear ? '0 : upd_valid;
   end

   always_ff @(posedge clock) begin
      rd_keys_ff  <= key_mem[bucket_ff];
      rd_valid_ff <= valid_mem[bucket_ff];
      if (key_we) begin
         key_mem[bucket_ff] <= new_keys;
      end
      if (valid_we) begin
         valid_mem[valid_addr] <= wr_valid;
      end
   end

   // Response payload register
   hse_pkg::hse_rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   // A full-bucket flag only comes with a miss
   a_status_miss: assert property (@(posedge clock) disable iff (reset)
      cmd.update && rsp_in.status |-> !rsp_in.present)
      else $error("full-bucket flag raised on a hit");

   // The row is never written while the clearing sweep runs
   a_clear_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !cmd.update && !key_we)
      else $error("row update during clearing sweep");

   // The sweep index only moves while clearing
   a_sweep_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.clear |=> $stable(clr_cnt_ff))
      else $error("sweep index moved outside clearing");
`endif

endmodule

`default_nettype wire

@@ src/hse_ctrl.sv @@
// ----------------------------------------------------------------------------
// hse_ctrl: sequencing controller for the hash set engine
// Runs the reset sweep, takes one request transaction at a time, steps it
// through the index pipeline and the row update, and owns response valid.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output hse_pkg::hse_cmd_type  cmd,
   input  hse_pkg::hse_stat_type stat
);

   hse_pkg::hse_state_type state_ff;
   hse_pkg::hse_state_type state_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;

   // State and response valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hse_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         hse_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = hse_pkg::ST_IDLE;
            end
         end
         hse_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = hse_pkg::ST_QUOT;
            end
         end
         hse_pkg::ST_QUOT: state_in = hse_pkg::ST_PROD;
         hse_pkg::ST_PROD: state_in = hse_pkg::ST_MOD;
         hse_pkg::ST_MOD:  state_in = hse_pkg::ST_READ;
         hse_pkg::ST_READ: begin
            // row is re-read each cycle; move on once the response slot frees
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = hse_pkg::ST_UPDATE;
            end
         end
         hse_pkg::ST_UPDATE: begin
            cmd.update   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = hse_pkg::ST_IDLE;
         end
         default: state_in = hse_pkg::ST_CLEAR;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // The update never overwrites a response still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      state_ff == hse_pkg::ST_UPDATE |-> !rsp_valid_ff)
      else $error("response overwritten");

   // No request transaction is taken during the sweep
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      state_ff == hse_pkg::ST_CLEAR |-> !req_ready)
      else $error("request taken during clearing sweep");

   // An accepted request starts the index pipeline
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == hse_pkg::ST_QUOT)
      else $error("accepted request not started");

   // A response appears only right after a row update
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == hse_pkg::ST_UPDATE))
      else $error("response without update");
`endif

endmodule

`default_nettype wire

@@ src/hash_set_engine.sv @@
// ----------------------------------------------------------------------------
// hash_set_engine: key set in a bucketed hash table
// Add, remove and contains requests on a fixed-way bucket table.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request transaction: kind (add, remove, contains) and
//   key. rsp_* returns exactly one response per request, in order: present
//   (key was in the set before the request) and status (add dropped because
//   the bucket was full). Both channels use valid/ready.
//   A request accepted in idle steps through the QUOT, PROD, MOD, READ and
//   UPDATE states; its response turns valid as UPDATE is left. The bucket
//   index comes from two registered multiplies and a corrected subtract,
//   then the row is read and written back before the next request is taken.
//   req_ready is high only in idle, and idle is reached while the previous
//   response may still sit in the output register.
//   A stalled receiver holds the next request before its row update until
//   the output register is taken; the table is not touched while waiting.
//   Reset: synchronous. The valid rows are then swept to empty, one bucket
//   row a cycle, over all BUCKETS rows; no request is taken meanwhile.
//   Keys are masked to KEY_BITS; the bucket is the masked key mod BUCKETS.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_set_engine #(
   parameter int unsigned BUCKETS  = 1024,
   parameter int unsigned WAYS     = 4,
   parameter int unsigned KEY_BITS = 20
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  hse_pkg::hse_req_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output hse_pkg::hse_rsp_type rsp_data
);

   hse_pkg::hse_cmd_type  cmd;
   hse_pkg::hse_stat_type stat;

   // Sequencing
   hse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Index, storage and compare
   hse_datapath #(
      .BUCKETS  (BUCKETS),
      .WAYS     (WAYS),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

@@ tb/sv/hash_set_engine_checker.sv @@
// ----------------------------------------------------------------------------
// hash_set_engine_checker: response predictor and scoreboard
// Watches the request and response channels of the hash set engine. Every
// accepted request is applied to a local copy of the bucket table, and the
// expected response is queued. Every accepted response is compared field
// by field with the oldest queued one. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hash_set_engine_checker #(
   parameter int unsigned BUCKETS  = 1024,
   parameter int unsigned WAYS     = 4,
   parameter int unsigned KEY_BITS = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  hse_pkg::hse_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  hse_pkg::hse_rsp_type rsp_data,
   output int                   fail_count,
   output int                   outstanding
);

   localparam int unsigned SLOTS = BUCKETS * WAYS;

   // Local copy of the bucket table
   logic [KEY_BITS-1:0] table_key  [SLOTS];
   logic                table_live [SLOTS];

   // Responses owed by the engine, oldest first
   hse_pkg::hse_rsp_type owed_rsps[$];

   // Apply one request to the table copy and return its response
   function automatic hse_pkg::hse_rsp_type apply_set_op(hse_pkg::hse_req_type op);
      logic [KEY_BITS-1:0]  k;
      int unsigned          base;
      int                   hit;
      int                   free_way;
      hse_pkg::hse_rsp_type r;
      k        = KEY_BITS'(op.key);
      base     = (k % BUCKETS) * WAYS;
      hit      = -1;
      free_way = -1;
      for (int w = 0; w < WAYS; w++) begin
         if (table_live[base + w]) begin
            if (hit < 0 && table_key[base + w] == k) hit = w;
         end else if (free_way < 0) begin
            free_way = w;
         end
      end
      r.present = (hit >= 0);
      r.status  = 1'b0;
      case (op.kind)
         hse_pkg::KIND_ADD: begin
            if (hit < 0) begin
               if (free_way >= 0) begin
                  table_key[base + free_way]  = k;
                  table_live[base + free_way] = 1'b1;
               end else begin
                  r.status = 1'b1;   // bucket full, add dropped
               end
            end
         end
         hse_pkg::KIND_REMOVE: begin
            if (hit >= 0) table_live[base + hit] = 1'b0;
         end
         default: ;   // contains and the unused code leave the table alone
      endcase
      return r;
   endfunction

   // Scoreboard: responses checked before the request of the same edge
   always @(posedge clock) begin
      int                   errs;
      hse_pkg::hse_rsp_type want;
      errs = 0;
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) table_live[s] = 1'b0;
         owed_rsps.delete();
         fail_count  <= 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_rsps.size() == 0) begin
               $error("response transaction with none expected: present %0b status %0b",
                      rsp_data.present, rsp_data.status);
               errs++;
            end else begin
               want = owed_rsps.pop_front();
               if (rsp_data.present !== want.present) begin
                  $error("present: expected %0b, actual %0b", want.present, rsp_data.present);
                  errs++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0b, actual %0b", want.status, rsp_data.status);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready) owed_rsps.push_back(apply_set_op(req_data));
         fail_count  <= fail_count + errs;
         outstanding <= owed_rsps.size();
      end
   end

endmodule

@@ tb/sv/hash_set_engine_test.sv @@
// ----------------------------------------------------------------------------
// hash_set_engine_test: top level of the hash set engine testbench
// Drives add, remove and contains requests into the engine: a directed
// pass over the corner cases, then random traffic aimed at a few hot
// buckets so that they fill, overflow and drain. Both channels idle at
// random, and the receiver holds off once for a long stretch. The checker
// beside the engine scores every response; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hash_set_engine_test;

   localparam int unsigned BUCKETS     = 1024;
   localparam int unsigned WAYS        = 4;
   localparam int unsigned KEY_BITS    = 20;
   localparam int unsigned KEY_W       = hse_pkg::KEY_W;
   localparam logic [1:0]  KIND_UNUSED = 2'd3;
   localparam int          RANDOM_OPS  = 1700;
   localparam int          HOT_COUNT   = 6;
   localparam int          TAG_COUNT   = 8;
   localparam int          HOLD_CYCLES = 300;
   localparam int          DRAIN_WAIT  = 20;
   localparam int          CYCLE_LIMIT = 200000;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   hse_pkg::hse_req_type req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   hse_pkg::hse_rsp_type rsp_data;
   int                   fail_count;
   int                   outstanding;

   // Traffic shaping shared by the sender and the receiver
   bit          calm       = 1'b0;
   bit          hold_start = 1'b0;
   int          cycle_count = 0;

   hash_set_engine #(
      .BUCKETS  (BUCKETS),
      .WAYS     (WAYS),
      .KEY_BITS (KEY_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   hash_set_engine_checker #(
      .BUCKETS  (BUCKETS),
      .WAYS     (WAYS),
      .KEY_BITS (KEY_BITS)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Offer one request transaction and wait until it is taken
   task automatic send_op(input logic [1:0] kind, input logic [KEY_W-1:0] key);
      while (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{kind: kind, key: key};
      do @(posedge clock); while (!req_ready);
   endtask

   // Key built from a tag and a bucket index
   function automatic logic [KEY_W-1:0] bucket_key(int unsigned tag, int unsigned bucket);
      return KEY_W'(tag * BUCKETS + bucket);
   endfunction

   // Receiver: random back-pressure, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_start) begin
            hold_start = 1'b0;
            rsp_ready <= 1'b0;
            for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clock);
         end
         rsp_ready <= calm || ($urandom_range(99) >= 11);
      end
   end

   // Run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("hash_set_engine_test: FAIL");
      $finish;
   end

   // Stimulus and verdict
   initial begin
      int unsigned      hot_bucket [HOT_COUNT];
      int unsigned      hot_tag    [TAG_COUNT];
      int unsigned      full_b;
      int unsigned      pick;
      logic [1:0]       kind;
      logic [KEY_W-1:0] key;

      for (int c = 0; c < 6; c++) @(posedge clock);
      reset <= 1'b0;

      // Directed: key extremes, duplicate add, full bucket, reuse of a freed way
      full_b = 10'h2A5;
      send_op(hse_pkg::KIND_ADD,      '0);
      send_op(hse_pkg::KIND_ADD,      '1);
      send_op(hse_pkg::KIND_CONTAINS, '0);
      send_op(hse_pkg::KIND_CONTAINS, '1);
      send_op(hse_pkg::KIND_ADD,      '0);
      send_op(hse_pkg::KIND_REMOVE,   20'h12345);
      for (int t = 1; t <= WAYS; t++) send_op(hse_pkg::KIND_ADD, bucket_key(t, full_b));
      send_op(hse_pkg::KIND_ADD,      bucket_key(WAYS + 1, full_b));
      send_op(hse_pkg::KIND_CONTAINS, bucket_key(WAYS + 1, full_b));
      send_op(hse_pkg::KIND_REMOVE,   bucket_key(2, full_b));
      send_op(hse_pkg::KIND_ADD,      bucket_key(WAYS + 1, full_b));
      send_op(hse_pkg::KIND_CONTAINS, bucket_key(2, full_b));
      send_op(KIND_UNUSED,            bucket_key(WAYS + 1, full_b));
      send_op(hse_pkg::KIND_ADD,      bucket_key(2, full_b));
      send_op(hse_pkg::KIND_REMOVE,   '0);
      send_op(hse_pkg::KIND_CONTAINS, '0);
      send_op(hse_pkg::KIND_REMOVE,   '1);

      // Random: mostly hot buckets with a small tag pool so buckets overflow
      for (int i = 0; i < RANDOM_OPS; i++) begin
         if (i % 400 == 0) begin
            foreach (hot_bucket[b]) hot_bucket[b] = $urandom_range(BUCKETS - 1);
            foreach (hot_tag[t])    hot_tag[t]    = $urandom_range((1 << (KEY_W - 10)) - 1);
         end
         calm = (i >= 500 && i < 800);
         if (i == 1000) hold_start = 1'b1;

         pick = $urandom_range(99);
         if (pick < 45)      kind = hse_pkg::KIND_ADD;
         else if (pick < 75) kind = hse_pkg::KIND_REMOVE;
         else if (pick < 95) kind = hse_pkg::KIND_CONTAINS;
         else                kind = KIND_UNUSED;

         if ($urandom_range(99) < 85)
            key = bucket_key(hot_tag[$urandom_range(TAG_COUNT - 1)],
                             hot_bucket[$urandom_range(HOT_COUNT - 1)]);
         else
            key = KEY_W'($urandom);
         send_op(kind, key);
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      // Drain, then give late extra responses a chance to show
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      for (int c = 0; c < DRAIN_WAIT; c++) @(posedge clock);
      if (fail_count == 0) begin
         $display("hash_set_engine_test: PASS");
      end else begin
         $display("hash_set_engine_test: FAIL");
      end
      $finish;
   end

endmodule
